/* design/ecpa_pkg.sv */
`default_nettype none
package ecpa_pkg;

    typedef struct packed {
        logic [31:0] p_x;
        logic [31:0] p_y;
        logic [31:0] q_x;
        logic [31:0] q_y;
    } ecpa_in_t;

    typedef struct packed {
        logic [31:0] sum_x;
        logic [31:0] sum_y;
        logic [31:0] slope;
        logic        at_infinity;
    } ecpa_out_t;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_CURVE_A = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_RED,
        OP_INV,
        OP_MOV
    } ecpa_op_t;

    typedef enum logic [3:0] {
        SRC_PX,
        SRC_PY,
        SRC_QX,
        SRC_QY,
        SRC_A,
        SRC_T0,
        SRC_T1,
        SRC_T2,
        SRC_T3,
        SRC_THREE,
        SRC_RAW0,
        SRC_RAW1,
        SRC_RAW2,
        SRC_RAW3,
        SRC_RAWA
    } ecpa_src_t;

    typedef struct packed {
        ecpa_op_t  op;
        logic      start;
        ecpa_src_t src_a;
        ecpa_src_t src_b;
        ecpa_src_t dst;
        logic      load;
    } ecpa_cmd_t;

    typedef struct packed {
        logic done;
        logic no_inv;
        logic equal_pts;
        logic den_zero;
        logic mod_small;
    } ecpa_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED0,
        ST_RED1,
        ST_RED2,
        ST_RED3,
        ST_REDA,
        ST_BRANCH,
        ST_DBL_SQ,
        ST_DBL_3,
        ST_DBL_NUM,
        ST_DBL_DEN,
        ST_ADD_NUM,
        ST_ADD_DEN,
        ST_DEN_CHK,
        ST_INV,
        ST_LAM,
        ST_LSQ,
        ST_X1,
        ST_X3,
        ST_Y1,
        ST_Y2,
        ST_Y3,
        ST_OUT_INF,
        ST_OUT
    } ecpa_state_t;

endpackage
`default_nettype wire

/* design/ecpa_datapath.sv */
`default_nettype none
module ecpa_datapath
    import ecpa_pkg::*;
#(
    parameter int FIELD_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [FIELD_BITS-1:0] modulus,
    input  wire logic [FIELD_BITS-1:0] curve_a,
    input  wire ecpa_in_t              req,
    input  wire ecpa_cmd_t             cmd,
    output ecpa_sts_t                  sts,
    output logic [FIELD_BITS-1:0]      lam,
    output logic [FIELD_BITS-1:0]      x3,
    output logic [FIELD_BITS-1:0]      y3
);

    localparam int W = FIELD_BITS;
    localparam int CW = $clog2(2 * W + 2);
    localparam logic [W:0] ONE = {{W{1'b0}}, 1'b1};

    logic [W-1:0] px_reg, py_reg, qx_reg, qy_reg, a_reg;
    logic [W-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [W-1:0] opa, opb, res;

    // Shared multicycle unit: shift-add multiply, restoring remainder, and
    // binary extended Euclid inversion, one step per cycle.
    ecpa_op_t     op_reg;
    logic         busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0]   acc_reg;
    logic [W-1:0] x_reg, y_reg;
    logic [W:0]   u_reg, v_reg;
    logic [W:0]   b_reg, d_reg;
    logic         fail_reg;
    logic         done_reg;
    logic [W-1:0] out_reg;

    function automatic logic [W-1:0] pick(input ecpa_src_t s,
                                          input logic [W-1:0] px, py, qx, qy, a,
                                          t0, t1, t2, t3, r0, r1, r2, r3, ra);
        logic [W-1:0] v;
        v = '0;
        case (s)
            SRC_PX:    v = px;
            SRC_PY:    v = py;
            SRC_QX:    v = qx;
            SRC_QY:    v = qy;
            SRC_A:     v = a;
            SRC_T0:    v = t0;
            SRC_T1:    v = t1;
            SRC_T2:    v = t2;
            SRC_T3:    v = t3;
            SRC_THREE: v = W'(3);
            SRC_RAW0:  v = r0;
            SRC_RAW1:  v = r1;
            SRC_RAW2:  v = r2;
            SRC_RAW3:  v = r3;
            SRC_RAWA:  v = ra;
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign opa = pick(cmd.src_a, px_reg, py_reg, qx_reg, qy_reg, a_reg, t0_reg, t1_reg,
                      t2_reg, t3_reg, W'(req.p_x), W'(req.p_y), W'(req.q_x),
                      W'(req.q_y), curve_a);
    assign opb = pick(cmd.src_b, px_reg, py_reg, qx_reg, qy_reg, a_reg, t0_reg, t1_reg,
                      t2_reg, t3_reg, W'(req.p_x), W'(req.p_y), W'(req.q_x),
                      W'(req.q_y), curve_a);

    logic [W:0] m_ext;
    logic [W:0] add_s, acc2, acc3;
    logic [W:0] rem2;
    logic [W:0] red_s;
    logic       finish;
    assign m_ext = {1'b0, modulus};

    function automatic logic [W:0] addm(input logic [W:0] x, input logic [W:0] y,
                                        input logic [W:0] m);
        logic [W+1:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s >= {1'b0, m}) ? (W+1)'(s - {1'b0, m}) : s[W:0];
    endfunction

    function automatic logic [W:0] half(input logic [W:0] x, input logic [W:0] m);
        logic [W+1:0] s;
        s = x[0] ? ({1'b0, x} + {1'b0, m}) : {1'b0, x};
        return s[W+1:1];
    endfunction

    always_comb
    begin
        add_s = addm({1'b0, opa}, {1'b0, opb}, m_ext);
        acc2  = addm(acc_reg, acc_reg, m_ext);
        acc3  = y_reg[W-1] ? addm(acc2, {1'b0, x_reg}, m_ext) : acc2;
        rem2  = {acc_reg[W-1:0], y_reg[W-1]};
        red_s = (rem2 >= m_ext) ? (rem2 - m_ext) : rem2;
        res   = '0;
        case (cmd.op)
            OP_ADD:  res = add_s[W-1:0];
            OP_SUB:  res = (opa >= opb) ? (opa - opb) : (opa + (modulus - opb));
            OP_MOV:  res = opa;
            default: res = out_reg;
        endcase
        case (op_reg) inside
            OP_MUL, OP_RED:
                finish = busy_reg && (cnt_reg == CW'(W - 1));
            OP_INV:
                finish = busy_reg && (u_reg == '0 || v_reg == '0 || u_reg == ONE
                                      || v_reg == ONE || cnt_reg == CW'(2 * W + 1));
            default:
                finish = busy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_NONE;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= finish;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                x_reg    <= opa;
                y_reg    <= opb;
                fail_reg <= 1'b0;
                u_reg    <= {1'b0, opa};
                v_reg    <= m_ext;
                b_reg    <= ONE;
                d_reg    <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= !finish;
                case (op_reg)
                    OP_MUL:
                    begin
                        acc_reg <= acc3;
                        y_reg   <= {y_reg[W-2:0], 1'b0};
                        cnt_reg <= cnt_reg + 1'b1;
                        if (finish)
                            out_reg <= acc3[W-1:0];
                    end
                    OP_RED:
                    begin
                        // Restoring remainder of y by modulus, one bit a step.
                        acc_reg <= red_s;
                        y_reg   <= {y_reg[W-2:0], 1'b0};
                        cnt_reg <= cnt_reg + 1'b1;
                        if (finish)
                            out_reg <= red_s[W-1:0];
                    end
                    OP_INV:
                    begin
                        // Binary extended Euclid: b*x == u, d*x == v (mod m).
                        if (finish)
                        begin
                            if (u_reg == ONE)
                                out_reg <= b_reg[W-1:0];
                            else if (v_reg == ONE)
                                out_reg <= d_reg[W-1:0];
                            else
                                fail_reg <= 1'b1;
                        end
                        else if (!u_reg[0])
                        begin
                            u_reg <= u_reg >> 1;
                            b_reg <= half(b_reg, m_ext);
                        end
                        else if (!v_reg[0])
                        begin
                            v_reg <= v_reg >> 1;
                            d_reg <= half(d_reg, m_ext);
                        end
                        else if (u_reg >= v_reg)
                        begin
                            u_reg   <= u_reg - v_reg;
                            b_reg   <= (b_reg >= d_reg) ? (b_reg - d_reg)
                                                        : (b_reg + (m_ext - d_reg));
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        else
                        begin
                            v_reg   <= v_reg - u_reg;
                            d_reg   <= (d_reg >= b_reg) ? (d_reg - b_reg)
                                                        : (d_reg + (m_ext - b_reg));
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            case (cmd.dst)
                SRC_PX:  px_reg <= res;
                SRC_PY:  py_reg <= res;
                SRC_QX:  qx_reg <= res;
                SRC_QY:  qy_reg <= res;
                SRC_A:   a_reg  <= res;
                SRC_T0:  t0_reg <= res;
                SRC_T1:  t1_reg <= res;
                SRC_T2:  t2_reg <= res;
                SRC_T3:  t3_reg <= res;
                default: t3_reg <= t3_reg;
            endcase
        end
    end

    assign sts.done      = done_reg;
    assign sts.no_inv    = fail_reg;
    assign sts.equal_pts = (px_reg == qx_reg) && (py_reg == qy_reg);
    assign sts.den_zero  = (t1_reg == '0);
    assign sts.mod_small = (modulus < W'(2));
    assign lam = t2_reg;
    assign x3  = t3_reg;
    assign y3  = t0_reg;

endmodule
`default_nettype wire

/* design/ecpa_ctrl.sv */
`default_nettype none
module ecpa_ctrl
    import ecpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire ecpa_sts_t sts,
    output ecpa_cmd_t      cmd,
    output logic           inf
);

    ecpa_state_t state_reg, state_next;
    logic        issued_reg, issued_next;
    logic        inf_reg, inf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            inf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            inf_reg    <= inf_next;
        end
    end

    // One multicycle step: issue once, load result when the unit is done.
    function automatic ecpa_cmd_t step(input ecpa_op_t op, input ecpa_src_t a,
                                       input ecpa_src_t b, input ecpa_src_t d,
                                       input logic issued, input logic done);
        ecpa_cmd_t c;
        c.op    = op;
        c.start = !issued;
        c.src_a = a;
        c.src_b = b;
        c.dst   = d;
        c.load  = issued && done;
        return c;
    endfunction

    function automatic ecpa_cmd_t quick(input ecpa_op_t op, input ecpa_src_t a,
                                        input ecpa_src_t b, input ecpa_src_t d);
        ecpa_cmd_t c;
        c.op    = op;
        c.start = 1'b0;
        c.src_a = a;
        c.src_b = b;
        c.dst   = d;
        c.load  = 1'b1;
        return c;
    endfunction

    always_comb
    begin
        logic adv;
        state_next  = state_reg;
        issued_next = issued_reg;
        inf_next    = inf_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '{op: OP_NONE, start: 1'b0, src_a: SRC_PX, src_b: SRC_PX,
                        dst: SRC_PX, load: 1'b0};
        adv         = issued_reg && sts.done;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                inf_next   = sts.mod_small;
                state_next = sts.mod_small ? ST_OUT : ST_RED0;
            end
            ST_RED0, ST_RED1, ST_RED2, ST_RED3, ST_REDA:
            begin
                case (state_reg)
                    ST_RED0: cmd = step(OP_RED, SRC_PX, SRC_RAW0, SRC_PX, issued_reg, sts.done);
                    ST_RED1: cmd = step(OP_RED, SRC_PX, SRC_RAW1, SRC_PY, issued_reg, sts.done);
                    ST_RED2: cmd = step(OP_RED, SRC_PX, SRC_RAW2, SRC_QX, issued_reg, sts.done);
                    ST_RED3: cmd = step(OP_RED, SRC_PX, SRC_RAW3, SRC_QY, issued_reg, sts.done);
                    default: cmd = step(OP_RED, SRC_PX, SRC_RAWA, SRC_A, issued_reg, sts.done);
                endcase
                issued_next = !adv;
                if (adv)
                    state_next = ecpa_state_t'(state_reg + 5'd1);
            end
            ST_BRANCH:
                state_next = sts.equal_pts ? ST_DBL_SQ : ST_ADD_NUM;
            ST_DBL_SQ, ST_DBL_3, ST_LAM, ST_LSQ, ST_Y2, ST_INV:
            begin
                case (state_reg)
                    ST_DBL_SQ: cmd = step(OP_MUL, SRC_PX, SRC_PX, SRC_T0, issued_reg, sts.done);
                    ST_DBL_3:  cmd = step(OP_MUL, SRC_T0, SRC_THREE, SRC_T0, issued_reg, sts.done);
                    ST_INV:    cmd = step(OP_INV, SRC_T1, SRC_T1, SRC_T1, issued_reg, sts.done);
                    ST_LAM:    cmd = step(OP_MUL, SRC_T0, SRC_T1, SRC_T2, issued_reg, sts.done);
                    ST_LSQ:    cmd = step(OP_MUL, SRC_T2, SRC_T2, SRC_T3, issued_reg, sts.done);
                    default:   cmd = step(OP_MUL, SRC_T2, SRC_T0, SRC_T0, issued_reg, sts.done);
                endcase
                if (state_reg == ST_INV && adv && sts.no_inv)
                    cmd.load = 1'b0;
                issued_next = !adv;
                if (adv)
                begin
                    if (state_reg == ST_INV && sts.no_inv)
                    begin
                        inf_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else if (state_reg == ST_DBL_3)
                        state_next = ST_DBL_NUM;
                    else if (state_reg == ST_DBL_SQ)
                        state_next = ST_DBL_3;
                    else
                        state_next = ecpa_state_t'(state_reg + 5'd1);
                end
            end
            ST_DBL_NUM:
            begin
                cmd        = quick(OP_ADD, SRC_T0, SRC_A, SRC_T0);
                state_next = ST_DBL_DEN;
            end
            ST_DBL_DEN:
            begin
                cmd        = quick(OP_ADD, SRC_PY, SRC_PY, SRC_T1);
                state_next = ST_DEN_CHK;
            end
            ST_ADD_NUM:
            begin
                cmd        = quick(OP_SUB, SRC_QY, SRC_PY, SRC_T0);
                state_next = ST_ADD_DEN;
            end
            ST_ADD_DEN:
            begin
                cmd        = quick(OP_SUB, SRC_QX, SRC_PX, SRC_T1);
                state_next = ST_DEN_CHK;
            end
            ST_DEN_CHK:
            begin
                inf_next   = sts.den_zero;
                state_next = sts.den_zero ? ST_OUT : ST_INV;
            end
            ST_X1:
            begin
                cmd        = quick(OP_SUB, SRC_T3, SRC_PX, SRC_T3);
                state_next = ST_X3;
            end
            ST_X3:
            begin
                cmd        = quick(OP_SUB, SRC_T3, SRC_QX, SRC_T3);
                state_next = ST_Y1;
            end
            ST_Y1:
            begin
                cmd        = quick(OP_SUB, SRC_PX, SRC_T3, SRC_T0);
                state_next = ST_Y2;
            end
            ST_Y3:
            begin
                cmd        = quick(OP_SUB, SRC_T0, SRC_PY, SRC_T0);
                state_next = ST_OUT;
            end
            ST_OUT_INF:
                state_next = ST_OUT;
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                    inf_next   = 1'b0;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign inf = inf_reg;

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_OUT)
        else $error("result offered outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && out_valid) == 1'b0)
        else $error("request accepted while result pending");
    a_issue_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !cmd.start)
        else $error("unit started twice in a row");

endmodule
`default_nettype wire

/* design/ec_point_add_prime_field.sv */
`default_nettype none
// Adds two affine points on y^2 = x^3 + a x + b over GF(p) for the configured odd
// modulus; one request is taken at a time and its result is held until taken.
// Input reduction of the four coordinates and a, three (addition) or five (doubling)
// multiplications and the binary Euclid inverse all run on one shared bit-serial
// arithmetic unit, plus direct modular add and subtract steps; an addition whose
// denominator is zero ends after the denominator check.
// A zero or non-invertible denominator, or a modulus below two, gives the point
// at infinity with all other result fields zero.
module ec_point_add_prime_field
    import ecpa_pkg::*;
#(
    parameter int FIELD_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [FIELD_BITS-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ecpa_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ecpa_out_t                  out_data
);

    logic [FIELD_BITS-1:0] modulus_reg, curve_a_reg;
    logic [FIELD_BITS-1:0] lam, x3, y3;
    ecpa_in_t  req_reg;
    ecpa_cmd_t cmd;
    ecpa_sts_t sts;
    logic      inf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= FIELD_BITS'(23);
            curve_a_reg <= FIELD_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS: modulus_reg <= cfg_data;
                REG_CURVE_A: curve_a_reg <= cfg_data;
                default:     modulus_reg <= modulus_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
    end

    ecpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .inf       (inf)
    );

    ecpa_datapath #(.FIELD_BITS(FIELD_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .curve_a (curve_a_reg),
        .req     (req_reg),
        .cmd     (cmd),
        .sts     (sts),
        .lam     (lam),
        .x3      (x3),
        .y3      (y3)
    );

    assign out_data.sum_x       = inf ? '0 : 32'(x3);
    assign out_data.sum_y       = inf ? '0 : 32'(y3);
    assign out_data.slope       = inf ? '0 : 32'(lam);
    assign out_data.at_infinity = inf;

endmodule
`default_nettype wire
